// ----- rtl/core/ikvt_pkg.sv -----
package ikvt_pkg;

	// Default capacity of the table.
	localparam int ENTRIES_DEFAULT = 64;

	// Operation codes carried on the cmd field.
	localparam logic CMD_SET  = 1'b0;
	localparam logic CMD_FIND = 1'b1;

	// Result status codes.
	typedef enum logic [1:0] {
		STATUS_HIT    = 2'd0,
		STATUS_MISS   = 2'd1,
		STATUS_INSERT = 2'd2,
		STATUS_FULL   = 2'd3
	} status_t;

endpackage

// ----- rtl/core/int_key_int_value_table.sv -----
// Associative table of 32-bit signed keys and 32-bit signed values, searched linearly.
// Input channel (in_valid / in_stall): one transfer carries cmd, key and value.
// A set (cmd 0) overwrites the value of a matching entry or appends a new entry.
// A find (cmd 1) returns the stored value of a matching entry.
// Output channel (out_valid / out_stall): exactly one result transfer per input
// transfer, with status (found or updated, find miss, inserted, table full) and
// read_value, which is zero for every result other than a find hit.
// For each item, one key comparator walks the stored entries one per
// cycle, with the key memory read registered ahead of the compare,
// followed by an action step to write the table or read the value memory
// and a finish step to load the output register. The scan stops early at
// the first matching entry.
// in_stall stays high while an item is being processed; the block takes the
// next item as soon as the result has been loaded into the output register,
// even if the receiver is still stalling that result, so items are handled
// one at a time.
// When out_stall is high the result is held unchanged in the output register,
// and a finished item waits for that register to free before it is loaded.
// Reset empties the table (the entry count is cleared, the memories are left
// as they are) and drops any item in flight; no clearing pass is needed.
module int_key_int_value_table #(
	parameter int ENTRIES = ikvt_pkg::ENTRIES_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               cmd,
	input  logic signed [31:0] key,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic signed [31:0] read_value
);

	// Count width holds ENTRIES itself; address width indexes ENTRIES entries.
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_ACT,
		ST_FINISH
	} state_t;

	// Storage: keys and values, read through registered ports.
	logic [31:0] key_mem [ENTRIES];
	logic [31:0] val_mem [ENTRIES];

	state_t            state_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     scan_idx_q;
	logic              pend_q;
	logic [AW-1:0]     pend_idx_q;
	logic              hit_q;
	logic [AW-1:0]     hit_idx_q;
	logic              cmd_q;
	logic [31:0]       key_q;
	logic [31:0]       value_q;
	logic [31:0]       key_rd_q;
	logic [31:0]       val_rd_q;
	ikvt_pkg::status_t status_pend_q;
	logic              out_valid_q;
	logic [1:0]        status_q;
	logic [31:0]       read_value_q;

	logic in_xfer;
	logic match;
	logic scan_done;
	logic full;
	logic out_free;
	logic key_we;
	logic val_we;
	logic [AW-1:0] val_waddr;

	assign in_stall   = (state_q != ST_IDLE);
	assign in_xfer    = in_valid && !in_stall;
	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign read_value = read_value_q;

	// The comparator sees the key read in the previous cycle.
	assign match     = pend_q && (key_rd_q == key_q);
	assign scan_done = (scan_idx_q == count_q);
	assign full      = (count_q == CW'(ENTRIES));
	assign out_free  = !out_valid_q || !out_stall;

	// Table updates happen only in the action step.
	assign key_we    = (state_q == ST_ACT) && (cmd_q == ikvt_pkg::CMD_SET) && !hit_q && !full;
	assign val_we    = (state_q == ST_ACT) && (cmd_q == ikvt_pkg::CMD_SET) && (hit_q || !full);
	assign val_waddr = hit_q ? hit_idx_q : count_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[count_q[AW-1:0]] <= key_q;
		end
		key_rd_q <= key_mem[scan_idx_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (val_we) begin
			val_mem[val_waddr] <= value_q;
		end
		val_rd_q <= val_mem[hit_idx_q];
	end

	// Item payload registers are only loaded on an input transfer.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cmd_q   <= cmd;
			key_q   <= key;
			value_q <= value;
		end
	end

	// Sequencer with the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			count_q       <= '0;
			scan_idx_q    <= '0;
			pend_q        <= 1'b0;
			pend_idx_q    <= '0;
			hit_q         <= 1'b0;
			hit_idx_q     <= '0;
			status_pend_q <= ikvt_pkg::STATUS_MISS;
			out_valid_q   <= 1'b0;
			status_q      <= '0;
			read_value_q  <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						scan_idx_q <= '0;
						pend_q     <= 1'b0;
						hit_q      <= 1'b0;
						state_q    <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (match) begin
						hit_q     <= 1'b1;
						hit_idx_q <= pend_idx_q;
						state_q   <= ST_ACT;
					end else if (scan_done) begin
						hit_q   <= 1'b0;
						state_q <= ST_ACT;
					end else begin
						// The key memory reads entry scan_idx_q this cycle.
						pend_q     <= 1'b1;
						pend_idx_q <= scan_idx_q[AW-1:0];
						scan_idx_q <= scan_idx_q + CW'(1);
					end
				end
				ST_ACT: begin
					if (hit_q) begin
						status_pend_q <= ikvt_pkg::STATUS_HIT;
					end else if (cmd_q == ikvt_pkg::CMD_FIND) begin
						status_pend_q <= ikvt_pkg::STATUS_MISS;
					end else if (!full) begin
						status_pend_q <= ikvt_pkg::STATUS_INSERT;
						count_q       <= count_q + CW'(1);
					end else begin
						status_pend_q <= ikvt_pkg::STATUS_FULL;
					end
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						status_q    <= status_pend_q;
						if (hit_q && (cmd_q == ikvt_pkg::CMD_FIND)) begin
							read_value_q <= val_rd_q;
						end else begin
							read_value_q <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The entry count never passes the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(ENTRIES))
		else $error("entry count above capacity");

	// A full table keeps its count through the action step.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ACT) && (count_q == CW'(ENTRIES)) |=> count_q == CW'(ENTRIES))
		else $error("entry count changed while full");

	// Only a find hit carries a non-zero value.
	a_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (status_q != ikvt_pkg::STATUS_HIT) |-> read_value_q == '0)
		else $error("non-zero value on a result other than a hit");

	// A dropped set is only reported when the table is full.
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (status_q == ikvt_pkg::STATUS_FULL) |-> full)
		else $error("full status with room in the table");

	// The block takes no item while one is being processed.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) || (state_q == ST_ACT) |-> in_stall)
		else $error("input open during processing");

endmodule

// ----- dv/tb_top.sv -----
module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	// Capacity of the table under test, taken from the package default.
	localparam int TABLE_DEPTH = ikvt_pkg::ENTRIES_DEFAULT;
	// Length of the deliberate hold-off on the result channel, in cycles.
	localparam int LONG_HOLD = 400;
	// Watchdog limit.
	localparam int CYCLE_LIMIT = 1_000_000;
	// Cycles to wait after the last expected result. This covers one full
	// scan and the output stages.
	localparam int DRAIN_CYCLES = TABLE_DEPTH + 8;

	// One expected result transfer.
	typedef struct packed {
		ikvt_pkg::status_t  status_code;
		logic signed [31:0] found_value;
	} lookup_result_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic               cmd;
	logic signed [31:0] key;
	logic signed [31:0] value;
	logic               out_valid;
	logic               out_stall;
	logic [1:0]         status;
	logic signed [31:0] read_value;

	// The testbench keeps its own copy of the table. It is updated at the
	// moment each input transfer is accepted, so it always reflects the
	// state that the block will see when it handles that item.
	logic [31:0] table_keys [TABLE_DEPTH];
	logic [31:0] table_vals [TABLE_DEPTH];
	int          table_fill = 0;

	lookup_result_t pending_results [$];
	int             fail_count = 0;
	int             cycle_count = 0;

	// The sender works in bursts. This counts the transfers left in the
	// current burst before a gap is inserted.
	int burst_left = 0;

	// A single request for the long hold-off. It is raised by the test and
	// served once by the receiver process.
	logic hold_req = 1'b0;
	bit   hold_taken = 1'b0;

	int_key_int_value_table #(
		.ENTRIES(TABLE_DEPTH)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.key       (key),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.read_value(read_value)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog. If the block hangs, the run ends here with a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Works out the result of one item against the table copy and applies
	// any change that the item makes. The scan goes in insertion order and
	// stops at the first entry whose key matches in all 32 bits.
	function automatic lookup_result_t table_apply(input logic op, input logic [31:0] k,
			input logic [31:0] v);
		lookup_result_t res;
		int             hit_idx;
		hit_idx = -1;
		for (int i = 0; i < table_fill; i++) begin
			if (hit_idx < 0 && table_keys[i] == k)
				hit_idx = i;
		end
		res.found_value = '0;
		if (op == ikvt_pkg::CMD_FIND) begin
			if (hit_idx >= 0) begin
				res.status_code = ikvt_pkg::STATUS_HIT;
				res.found_value = table_vals[hit_idx];
			end else begin
				res.status_code = ikvt_pkg::STATUS_MISS;
			end
		end else if (hit_idx >= 0) begin
			// An existing key is updated even when the table is full.
			table_vals[hit_idx] = v;
			res.status_code = ikvt_pkg::STATUS_HIT;
		end else if (table_fill < TABLE_DEPTH) begin
			table_keys[table_fill] = k;
			table_vals[table_fill] = v;
			table_fill++;
			res.status_code = ikvt_pkg::STATUS_INSERT;
		end else begin
			// A new key cannot go into a full table: nothing changes.
			res.status_code = ikvt_pkg::STATUS_FULL;
		end
		return res;
	endfunction

	// Checks each result transfer against the oldest expectation, and then
	// records the expectation for any input transfer at the same edge. An
	// item's result is registered after its scan, so the two never coincide.
	always @(posedge clk) begin
		lookup_result_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					$error("result transfer with no item outstanding: status %0d read_value %0d",
						status, read_value);
					fail_count++;
				end else begin
					want = pending_results.pop_front();
					if (status !== want.status_code) begin
						$error("status mismatch: expected %0d, actual %0d",
							want.status_code, status);
						fail_count++;
					end
					if (read_value !== want.found_value) begin
						$error("read_value mismatch: expected %0d, actual %0d",
							want.found_value, read_value);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall)
				pending_results.push_back(table_apply(cmd, key, value));
		end
	end

	// Receiver. It changes between stretches of no stalling, light and heavy
	// random stalling, and short solid stalls. When the test asks for it, it
	// also holds off once for a long stretch so that the block fills up.
	initial begin
		int stretch_left;
		int stretch_kind;
		out_stall <= 1'b0;
		stretch_left = 0;
		stretch_kind = 0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				if (stretch_left == 0) begin
					stretch_kind = $urandom_range(0, 3);
					stretch_left = (stretch_kind == 3) ? $urandom_range(1, 12)
						: $urandom_range(1, 40);
				end
				stretch_left--;
				case (stretch_kind)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					2: out_stall <= ($urandom_range(0, 3) != 0);
					default: out_stall <= 1'b1;
				endcase
			end
		end
	end

	// Offers one item and returns at the edge where it is accepted. The valid
	// is left high so that the next item of a burst follows straight on; a
	// gap lowers it once and raises it again on a later edge.
	task automatic send_item(input logic op, input logic [31:0] k, input logic [31:0] v);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 12);
			gap = $urandom_range(1, 8);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		burst_left--;
		in_valid <= 1'b1;
		cmd      <= op;
		key      <= k;
		value    <= v;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	// Chooses a key for random traffic: mostly stored keys, some keys one bit
	// away from a stored key, some extreme keys and some fresh ones.
	function automatic logic [31:0] pick_key();
		int          sel;
		logic [31:0] k;
		sel = $urandom_range(0, 99);
		if (table_fill > 0 && sel < 55) begin
			k = table_keys[$urandom_range(0, table_fill - 1)];
		end else if (table_fill > 0 && sel < 65) begin
			k = table_keys[$urandom_range(0, table_fill - 1)] ^ (32'h1 << $urandom_range(0, 31));
		end else if (sel < 72) begin
			case ($urandom_range(0, 3))
				0: k = 32'h0000_0000;
				1: k = 32'hFFFF_FFFF;
				2: k = 32'h8000_0000;
				default: k = 32'h7FFF_FFFF;
			endcase
		end else begin
			k = $urandom;
		end
		return k;
	endfunction

	// Extreme keys and values on an empty and then lightly filled table:
	// a miss with nothing stored, inserts, hits, updates of a stored entry,
	// and keys that differ from a stored one in a single bit.
	task automatic test_empty_and_extremes();
		send_item(ikvt_pkg::CMD_FIND, 32'h0000_0000, 32'h0000_0000);
		send_item(ikvt_pkg::CMD_SET, 32'h8000_0000, 32'h7FFF_FFFF);
		send_item(ikvt_pkg::CMD_SET, 32'h7FFF_FFFF, 32'h8000_0000);
		send_item(ikvt_pkg::CMD_SET, 32'h0000_0000, 32'h0000_0000);
		send_item(ikvt_pkg::CMD_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		// The value field of a find must have no effect.
		send_item(ikvt_pkg::CMD_FIND, 32'h8000_0000, 32'hFFFF_FFFF);
		send_item(ikvt_pkg::CMD_FIND, 32'h7FFF_FFFF, 32'h5555_5555);
		send_item(ikvt_pkg::CMD_FIND, 32'h0000_0000, 32'hAAAA_AAAA);
		send_item(ikvt_pkg::CMD_FIND, 32'hFFFF_FFFF, 32'h0000_0000);
		send_item(ikvt_pkg::CMD_FIND, 32'h8000_0001, 32'h0000_0000);
		send_item(ikvt_pkg::CMD_FIND, 32'hFFFF_FFFE, 32'h0000_0000);
		send_item(ikvt_pkg::CMD_FIND, 32'h0000_0001, 32'h0000_0000);
		send_item(ikvt_pkg::CMD_SET, 32'h8000_0000, 32'h1234_5678);
		send_item(ikvt_pkg::CMD_FIND, 32'h8000_0000, 32'h0000_0000);
		send_item(ikvt_pkg::CMD_SET, 32'h0000_0000, 32'hA5A5_A5A5);
		send_item(ikvt_pkg::CMD_FIND, 32'h0000_0000, 32'h0000_0000);
		send_item(ikvt_pkg::CMD_SET, 32'hFFFF_FFFF, 32'h0000_0000);
		send_item(ikvt_pkg::CMD_FIND, 32'hFFFF_FFFF, 32'h0000_0000);
	endtask

	// Fills the table with fresh random keys, mixed with finds, until it is
	// at capacity. Then a new key must be refused, a stored key must still
	// be updated, and both the deepest entry and a full-length miss are read.
	task automatic test_fill_to_capacity();
		int          sel;
		logic [31:0] deepest_key;
		while (table_fill < TABLE_DEPTH) begin
			sel = $urandom_range(0, 9);
			if (sel < 6)
				send_item(ikvt_pkg::CMD_SET, $urandom, $urandom);
			else
				send_item(ikvt_pkg::CMD_FIND, pick_key(), $urandom);
		end
		deepest_key = table_keys[TABLE_DEPTH - 1];
		send_item(ikvt_pkg::CMD_SET, 32'h0BAD_CAFE ^ deepest_key, 32'h1111_1111);
		send_item(ikvt_pkg::CMD_SET, 32'h8000_0000, 32'h2222_2222);
		send_item(ikvt_pkg::CMD_FIND, 32'h8000_0000, 32'h0000_0000);
		send_item(ikvt_pkg::CMD_SET, deepest_key, 32'h8000_0001);
		send_item(ikvt_pkg::CMD_FIND, deepest_key, 32'h0000_0000);
		send_item(ikvt_pkg::CMD_FIND, deepest_key ^ 32'h8000_0000, 32'h0000_0000);
	endtask

	// Random sets and finds over stored, near-miss, extreme and fresh keys.
	task automatic test_random_traffic(input int item_total);
		for (int n = 0; n < item_total; n++)
			send_item($urandom_range(0, 1) ? ikvt_pkg::CMD_FIND : ikvt_pkg::CMD_SET,
				pick_key(), $urandom);
	endtask

	// The receiver holds off for a long stretch while items keep coming, so
	// the output register and the finished item behind it fill up and the
	// block has to stall its input.
	task automatic test_output_backpressure(input int item_total);
		hold_req <= 1'b1;
		test_random_traffic(item_total);
	endtask

	initial begin
		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		cmd      <= ikvt_pkg::CMD_SET;
		key      <= '0;
		value    <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_and_extremes();
		test_fill_to_capacity();
		test_random_traffic(1650);
		test_output_backpressure(60);
		in_valid <= 1'b0;

		// Let every outstanding result arrive, then wait a further DRAIN_CYCLES
		// for any stray transfer to show up.
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
